// ===== rtl/core/mi2_pkg.sv =====
// ============================================================================
// mi2_pkg - shared types and constants for the 2x2 matrix inverse
// Output format, configuration register map and the saturating packer that
// turns a sign and a magnitude into a 32-bit signed Q16.16 value.
// ============================================================================
package mi2_pkg;

    // Result format
    localparam int OUT_W    = 32;
    localparam int OUT_FRAC = 16;
    localparam int LANES    = 4;

    // Largest magnitudes that fit the signed result
    localparam logic [63:0] OUT_MAX     = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] OUT_MIN_MAG = 64'h0000_0000_8000_0000;

    // Configuration port
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int ADDR_LSB = 2;
    localparam int THR_W    = 31;

    localparam logic [PADDR_W-ADDR_LSB-1:0] REG_THRESHOLD = 1'b0;
    localparam logic [THR_W-1:0]            THR_RESET     = 31'd1;

    typedef struct packed {
        logic             sat;
        logic [OUT_W-1:0] val;
    } sat_pack_t;

    // Build a signed result from sign and magnitude, clipping to 32 bits
    function automatic sat_pack_t sat_pack(input logic neg, input logic [63:0] mag);
        sat_pack_t r;
        r.sat = 1'b0;
        if (neg)
        begin
            if (mag > OUT_MIN_MAG)
            begin
                r.sat = 1'b1;
                r.val = OUT_MIN_MAG[OUT_W-1:0];
            end
            else
            begin
                r.val = OUT_W'(64'd0 - mag);
            end
        end
        else
        begin
            if (mag > OUT_MAX)
            begin
                r.sat = 1'b1;
                r.val = OUT_MAX[OUT_W-1:0];
            end
            else
            begin
                r.val = mag[OUT_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/mi2_div.sv =====
// ============================================================================
// mi2_div - pipelined restoring divider, several lanes over one divisor
// One quotient bit per stage, NUM_W stages. Each lane divides its own
// unsigned numerator by the shared unsigned divisor. A tag word and a valid
// bit ride along each stage; all stages advance together on enable.
// ============================================================================
module mi2_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 32,
    parameter int LANES = 4,
    parameter int TAG_W = 73
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        enable,
    input  logic                        start,
    input  logic [LANES-1:0][NUM_W-1:0] num,
    input  logic [DEN_W-1:0]            den,
    input  logic [TAG_W-1:0]            tag,
    output logic                        done,
    output logic [LANES-1:0][NUM_W-1:0] quo,
    output logic [TAG_W-1:0]            done_tag
);

    localparam int STG = NUM_W;

    // Numerator bits shift out at the top while quotient bits shift in below
    logic                        valid_reg [STG];
    logic [LANES-1:0][NUM_W-1:0] nq_reg    [STG];
    logic [TAG_W-1:0]            tag_reg   [STG];
    logic [LANES-1:0][DEN_W-1:0] rem_reg   [STG-1];
    logic [DEN_W-1:0]            den_reg   [STG-1];

    genvar i;
    for (i = 0; i < STG; i++)
    begin : g_stage
        logic                        valid_src;
        logic [LANES-1:0][NUM_W-1:0] nq_src;
        logic [LANES-1:0][NUM_W-1:0] nq_next;
        logic [LANES-1:0][DEN_W-1:0] rem_src;
        logic [LANES-1:0][DEN_W-1:0] rem_next;
        logic [DEN_W-1:0]            den_src;
        logic [TAG_W-1:0]            tag_src;

        // Select stage inputs: the ports for the first stage, else the prior stage
        if (i == 0)
        begin : g_first
            assign valid_src = start;
            assign nq_src    = num;
            assign rem_src   = '0;
            assign den_src   = den;
            assign tag_src   = tag;
        end
        else
        begin : g_rest
            assign valid_src = valid_reg[i-1];
            assign nq_src    = nq_reg[i-1];
            assign rem_src   = rem_reg[i-1];
            assign den_src   = den_reg[i-1];
            assign tag_src   = tag_reg[i-1];
        end

        // Trial subtract: bring down one numerator bit, keep the difference if it fits
        always_comb
        begin
            logic [DEN_W:0] trial;
            for (int l = 0; l < LANES; l++)
            begin
                trial = {rem_src[l], nq_src[l][NUM_W-1]};
                if (trial >= {1'b0, den_src})
                begin
                    rem_next[l] = DEN_W'(trial - {1'b0, den_src});
                    nq_next[l]  = {nq_src[l][NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = trial[DEN_W-1:0];
                    nq_next[l]  = {nq_src[l][NUM_W-2:0], 1'b0};
                end
            end
        end

        // Advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (enable)
            begin
                valid_reg[i] <= valid_src;
            end
        end

        // Advance the payload
        always_ff @(posedge clk)
        begin
            if (enable)
            begin
                nq_reg[i]  <= nq_next;
                tag_reg[i] <= tag_src;
            end
        end

        // Carry remainder and divisor to every stage but the last
        if (i < STG - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (enable)
                begin
                    rem_reg[i] <= rem_next;
                    den_reg[i] <= den_src;
                end
            end
        end
    end

    assign done     = valid_reg[STG-1];
    assign quo      = nq_reg[STG-1];
    assign done_tag = tag_reg[STG-1];

endmodule

// ===== rtl/core/matrix2x2_inverse.sv =====
// ============================================================================
// matrix2x2_inverse - streaming inverse of 2x2 signed fixed-point matrices
// Determinant, singular test against a threshold register, and adjugate
// divided by the determinant with round toward zero and 32-bit saturation.
// ============================================================================
// One matrix is taken per clock and one result leaves per clock while the
// output is not stalled. The default element format is Q8.8. From an input
// transfer to its result sit registers for the products, the determinant and
// its magnitude, one per quotient bit in the restoring divider
// (ELEM_WIDTH + FRAC_BITS + 16 bits), and one for saturation and result select.
// A result register plus one skid entry sit at the output, so a stall on the
// result side reaches item_stall in the following cycle. Write singular_threshold
// only while no item is in flight.
module matrix2x2_inverse
    import mi2_pkg::*;
#(
    parameter int ELEM_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,

    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [PADDR_W-1:0]           paddr,
    input  logic [PDATA_W-1:0]           pwdata,
    output logic [PDATA_W-1:0]           prdata,
    output logic                         pready,

    // Matrix input
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic signed [ELEM_WIDTH-1:0] elem_r0c0,
    input  logic signed [ELEM_WIDTH-1:0] elem_r0c1,
    input  logic signed [ELEM_WIDTH-1:0] elem_r1c0,
    input  logic signed [ELEM_WIDTH-1:0] elem_r1c1,

    // Inverse output
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic                         invertible,
    output logic                         saturated,
    output logic signed [OUT_W-1:0]      inv_r0c0,
    output logic signed [OUT_W-1:0]      inv_r0c1,
    output logic signed [OUT_W-1:0]      inv_r1c0,
    output logic signed [OUT_W-1:0]      inv_r1c1
);

    localparam int E      = ELEM_WIDTH;
    localparam int SH     = FRAC_BITS + OUT_FRAC;
    localparam int WSH    = OUT_FRAC - FRAC_BITS;
    localparam int PROD_W = 2 * E;
    localparam int DET_W  = PROD_W + 1;
    localparam int MAG_W  = PROD_W;
    localparam int NUM_W  = E + SH;
    localparam int TAG_W  = 1 + 2 * LANES + LANES * E;
    localparam int CMP_W  = (MAG_W > THR_W) ? MAG_W : THR_W;

    logic                         adv;
    logic [THR_W-1:0]             thr_reg;

    logic                         s1_valid_reg;
    logic [LANES-1:0][E-1:0]      s1_elem_reg;
    logic signed [PROD_W-1:0]     s1_ad_reg;
    logic signed [PROD_W-1:0]     s1_bc_reg;
    logic signed [PROD_W-1:0]     s1_ad_next;
    logic signed [PROD_W-1:0]     s1_bc_next;

    logic                         s2_valid_reg;
    logic [LANES-1:0][E-1:0]      s2_elem_reg;
    logic signed [DET_W-1:0]      s2_det_reg;

    logic                         s3_valid_reg;
    logic [MAG_W-1:0]             s3_det_mag_reg;
    logic [LANES-1:0]             s3_qneg_reg;
    logic [LANES-1:0]             s3_eneg_reg;
    logic [LANES-1:0][E-1:0]      s3_emag_reg;
    logic [MAG_W-1:0]             s3_det_mag_next;
    logic [LANES-1:0]             s3_qneg_next;
    logic [LANES-1:0]             s3_eneg_next;
    logic [LANES-1:0][E-1:0]      s3_emag_next;

    logic                         dv_sing;
    logic [LANES-1:0][NUM_W-1:0]  dv_num;
    logic [TAG_W-1:0]             dv_tag;
    logic                         dn_valid;
    logic [LANES-1:0][NUM_W-1:0]  dn_quo;
    logic [TAG_W-1:0]             dn_tag;
    logic                         dn_sing;
    logic [LANES-1:0]             dn_qneg;
    logic [LANES-1:0]             dn_eneg;
    logic [LANES-1:0][E-1:0]      dn_emag;

    logic                         res_valid_reg;
    logic                         res_invertible_reg;
    logic                         res_sat_reg;
    logic [LANES-1:0][OUT_W-1:0]  res_inv_reg;
    logic                         res_invertible_next;
    logic                         res_sat_next;
    logic [LANES-1:0][OUT_W-1:0]  res_inv_next;

    logic                         skid_full_reg;
    logic                         skid_full_next;
    logic                         skid_invertible_reg;
    logic                         skid_sat_reg;
    logic [LANES-1:0][OUT_W-1:0]  skid_inv_reg;

    // ------------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (psel && penable && pwrite && pready &&
                 (paddr[PADDR_W-1:ADDR_LSB] == REG_THRESHOLD))
        begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    assign prdata = (paddr[PADDR_W-1:ADDR_LSB] == REG_THRESHOLD) ? PDATA_W'(thr_reg) : '0;

    // ------------------------------------------------------------------------
    // Flow control: the whole pipeline advances while the skid entry is empty
    // ------------------------------------------------------------------------
    assign adv        = !skid_full_reg;
    assign item_stall = skid_full_reg;

    // ------------------------------------------------------------------------
    // Stage 1: cross products
    // ------------------------------------------------------------------------
    assign s1_ad_next = PROD_W'(elem_r0c0) * PROD_W'(elem_r1c1);
    assign s1_bc_next = PROD_W'(elem_r0c1) * PROD_W'(elem_r1c0);

    // ------------------------------------------------------------------------
    // Stage 3: determinant magnitude, element magnitudes and result signs
    // ------------------------------------------------------------------------
    always_comb
    begin
        logic det_neg;
        det_neg = s2_det_reg[DET_W-1];
        s3_det_mag_next = det_neg ? MAG_W'(-s2_det_reg) : MAG_W'(s2_det_reg);
        for (int k = 0; k < LANES; k++)
        begin
            s3_eneg_next[k] = s2_elem_reg[k][E-1];
            s3_emag_next[k] = s2_elem_reg[k][E-1] ? E'(-s2_elem_reg[k]) : s2_elem_reg[k];
        end
        // Adjugate: swap the diagonal, negate the off-diagonal
        s3_qneg_next[0] = s2_elem_reg[3][E-1] ^ det_neg;
        s3_qneg_next[1] = (!s2_elem_reg[1][E-1] && (|s2_elem_reg[1])) ^ det_neg;
        s3_qneg_next[2] = (!s2_elem_reg[2][E-1] && (|s2_elem_reg[2])) ^ det_neg;
        s3_qneg_next[3] = s2_elem_reg[0][E-1] ^ det_neg;
    end

    // Advance valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= item_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Advance payload of the front stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_elem_reg    <= {elem_r1c1, elem_r1c0, elem_r0c1, elem_r0c0};
            s1_ad_reg      <= s1_ad_next;
            s1_bc_reg      <= s1_bc_next;
            s2_elem_reg    <= s1_elem_reg;
            s2_det_reg     <= DET_W'(s1_ad_reg) - DET_W'(s1_bc_reg);
            s3_det_mag_reg <= s3_det_mag_next;
            s3_qneg_reg    <= s3_qneg_next;
            s3_eneg_reg    <= s3_eneg_next;
            s3_emag_reg    <= s3_emag_next;
        end
    end

    // ------------------------------------------------------------------------
    // Divider: adjugate magnitudes scaled to Q16.16 over the determinant
    // ------------------------------------------------------------------------
    assign dv_sing = (s3_det_mag_reg == '0) ||
                     (CMP_W'(s3_det_mag_reg) < CMP_W'(thr_reg));

    assign dv_num[0] = NUM_W'(s3_emag_reg[3]) << SH;
    assign dv_num[1] = NUM_W'(s3_emag_reg[1]) << SH;
    assign dv_num[2] = NUM_W'(s3_emag_reg[2]) << SH;
    assign dv_num[3] = NUM_W'(s3_emag_reg[0]) << SH;

    assign dv_tag = {dv_sing, s3_qneg_reg, s3_eneg_reg, s3_emag_reg};

    mi2_div #(
        .NUM_W (NUM_W),
        .DEN_W (MAG_W),
        .LANES (LANES),
        .TAG_W (TAG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .enable   (adv),
        .start    (s3_valid_reg),
        .num      (dv_num),
        .den      (s3_det_mag_reg),
        .tag      (dv_tag),
        .done     (dn_valid),
        .quo      (dn_quo),
        .done_tag (dn_tag)
    );

    assign dn_sing = dn_tag[TAG_W-1];
    assign dn_qneg = dn_tag[TAG_W-2 -: LANES];
    assign dn_eneg = dn_tag[TAG_W-2-LANES -: LANES];
    assign dn_emag = dn_tag[LANES*E-1:0];

    // ------------------------------------------------------------------------
    // Result stage: saturate and pick the inverse or the widened input
    // ------------------------------------------------------------------------
    always_comb
    begin
        sat_pack_t qp;
        sat_pack_t ep;
        logic      qsat;
        logic      esat;
        qsat = 1'b0;
        esat = 1'b0;
        for (int k = 0; k < LANES; k++)
        begin
            qp = sat_pack(dn_qneg[k], 64'(dn_quo[k]));
            ep = sat_pack(dn_eneg[k], 64'(dn_emag[k]) << WSH);
            qsat = qsat | qp.sat;
            esat = esat | ep.sat;
            res_inv_next[k] = dn_sing ? ep.val : qp.val;
        end
        res_sat_next        = dn_sing ? esat : qsat;
        res_invertible_next = !dn_sing;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= dn_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_invertible_reg <= res_invertible_next;
            res_sat_reg        <= res_sat_next;
            res_inv_reg        <= res_inv_next;
        end
    end

    // ------------------------------------------------------------------------
    // Skid entry: catch the result when the receiver stalls it
    // ------------------------------------------------------------------------
    always_comb
    begin
        if (skid_full_reg)
        begin
            skid_full_next = result_stall;
        end
        else
        begin
            skid_full_next = res_valid_reg && result_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else
        begin
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg)
        begin
            skid_invertible_reg <= res_invertible_reg;
            skid_sat_reg        <= res_sat_reg;
            skid_inv_reg        <= res_inv_reg;
        end
    end

    // Present the skid entry first, then the result register
    assign result_valid = skid_full_reg || res_valid_reg;
    assign invertible   = skid_full_reg ? skid_invertible_reg : res_invertible_reg;
    assign saturated    = skid_full_reg ? skid_sat_reg : res_sat_reg;
    assign inv_r0c0     = skid_full_reg ? skid_inv_reg[0] : res_inv_reg[0];
    assign inv_r0c1     = skid_full_reg ? skid_inv_reg[1] : res_inv_reg[1];
    assign inv_r1c0     = skid_full_reg ? skid_inv_reg[2] : res_inv_reg[2];
    assign inv_r1c1     = skid_full_reg ? skid_inv_reg[3] : res_inv_reg[3];

endmodule

// ===== test/mi2_inverse_checker.sv =====
// ============================================================================
// mi2_inverse_checker - result predictor and scoreboard for matrix2x2_inverse
// Watches the matrix and result channels and the register port. Every matrix
// transfer is turned into an expected inverse, and every result transfer is
// compared field by field with the oldest one waiting.
// ============================================================================
module mi2_inverse_checker
    import mi2_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    // Register port, watched for threshold writes
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    input  logic                      pready,

    // Matrix channel
    input  logic                      item_valid,
    input  logic                      item_stall,
    input  logic signed [15:0]        elem_r0c0,
    input  logic signed [15:0]        elem_r0c1,
    input  logic signed [15:0]        elem_r1c0,
    input  logic signed [15:0]        elem_r1c1,

    // Result channel
    input  logic                      result_valid,
    input  logic                      result_stall,
    input  logic                      invertible,
    input  logic                      saturated,
    input  logic signed [OUT_W-1:0]   inv_r0c0,
    input  logic signed [OUT_W-1:0]   inv_r0c1,
    input  logic signed [OUT_W-1:0]   inv_r1c0,
    input  logic signed [OUT_W-1:0]   inv_r1c1,

    output int                        failures,
    output int                        outstanding
);

    localparam int ELEM_W = 16;
    localparam int FRAC_W = 8;

    typedef logic signed [ELEM_W-1:0] elem_t;

    typedef struct packed {
        logic             invertible;
        logic             saturated;
        logic [OUT_W-1:0] r0c0;
        logic [OUT_W-1:0] r0c1;
        logic [OUT_W-1:0] r1c0;
        logic [OUT_W-1:0] r1c1;
    } inverse_t;

    inverse_t         inverse_q[$];
    logic [THR_W-1:0] threshold;
    int               fail_count = 0;
    int               waiting    = 0;

    assign failures    = fail_count;
    assign outstanding = waiting;

    // Magnitude of a signed 64-bit value
    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Clip a sign and magnitude to signed 32 bits; top bit flags a clip
    function automatic logic [OUT_W:0] clip_q16(input logic neg, input logic [63:0] mag);
        if (neg && mag > OUT_MIN_MAG)
            return {1'b1, OUT_MIN_MAG[OUT_W-1:0]};
        if (neg)
            return {1'b0, OUT_W'(64'd0 - mag)};
        if (mag > OUT_MAX)
            return {1'b1, OUT_MAX[OUT_W-1:0]};
        return {1'b0, mag[OUT_W-1:0]};
    endfunction

    // Element over determinant in Q16.16, truncated toward zero
    function automatic logic [OUT_W:0] scaled_quotient(input longint num, input longint det);
        logic [63:0] numer;
        logic [63:0] quo;
        logic        neg;
        numer = magnitude(num) << (FRAC_W + OUT_FRAC);
        quo   = numer / magnitude(det);
        neg   = ((num < 0) != (det < 0)) && (quo != 0);
        return clip_q16(neg, quo);
    endfunction

    // Expected result for one matrix under the given threshold
    function automatic inverse_t predict_inverse(input elem_t a, input elem_t b,
                                                 input elem_t c, input elem_t d,
                                                 input logic [THR_W-1:0] thr);
        longint           det;
        logic [63:0]      det_mag;
        logic [OUT_W:0]   e00;
        logic [OUT_W:0]   e01;
        logic [OUT_W:0]   e10;
        logic [OUT_W:0]   e11;
        inverse_t         r;
        det     = longint'(a) * longint'(d) - longint'(b) * longint'(c);
        det_mag = magnitude(det);
        if (det_mag == 0 || det_mag < {33'd0, thr})
        begin
            // singular: hand back the elements widened to Q16.16
            e00 = clip_q16(a < 0, magnitude(longint'(a)) << (OUT_FRAC - FRAC_W));
            e01 = clip_q16(b < 0, magnitude(longint'(b)) << (OUT_FRAC - FRAC_W));
            e10 = clip_q16(c < 0, magnitude(longint'(c)) << (OUT_FRAC - FRAC_W));
            e11 = clip_q16(d < 0, magnitude(longint'(d)) << (OUT_FRAC - FRAC_W));
            r.invertible = 1'b0;
        end
        else
        begin
            // adjugate: swap the diagonal, negate the off-diagonal
            e00 = scaled_quotient(longint'(d), det);
            e01 = scaled_quotient(-longint'(b), det);
            e10 = scaled_quotient(-longint'(c), det);
            e11 = scaled_quotient(longint'(a), det);
            r.invertible = 1'b1;
        end
        r.saturated = e00[OUT_W] | e01[OUT_W] | e10[OUT_W] | e11[OUT_W];
        r.r0c0      = e00[OUT_W-1:0];
        r.r0c1      = e01[OUT_W-1:0];
        r.r1c0      = e10[OUT_W-1:0];
        r.r1c1      = e11[OUT_W-1:0];
        return r;
    endfunction

    // Count a differing field, report the first few
    task automatic compare_field(input string field, input logic [OUT_W-1:0] want,
                                 input logic [OUT_W-1:0] got);
        if (want !== got)
        begin
            if (fail_count < 10)
                $display("ERROR %0t: %s expected %h got %h", $time, field, want, got);
            fail_count++;
        end
    endtask

    // Predict on matrix transfers, compare on result transfers
    always @(posedge clk or negedge rst_n)
    begin
        inverse_t want;
        if (!rst_n)
        begin
            threshold = THR_RESET;
            inverse_q.delete();
            waiting <= 0;
        end
        else
        begin
            // queue the expectation for this matrix
            if (item_valid && !item_stall)
                inverse_q.push_back(predict_inverse(elem_r0c0, elem_r0c1, elem_r1c0,
                                                    elem_r1c1, threshold));

            // check the result against the oldest expectation
            if (result_valid && !result_stall)
            begin
                if (inverse_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR %0t: result with nothing expected: %b %b %h %h %h %h",
                                 $time, invertible, saturated, inv_r0c0, inv_r0c1,
                                 inv_r1c0, inv_r1c1);
                    fail_count++;
                end
                else
                begin
                    want = inverse_q.pop_front();
                    compare_field("invertible", OUT_W'(want.invertible), OUT_W'(invertible));
                    compare_field("saturated", OUT_W'(want.saturated), OUT_W'(saturated));
                    compare_field("inv_r0c0", want.r0c0, inv_r0c0);
                    compare_field("inv_r0c1", want.r0c1, inv_r0c1);
                    compare_field("inv_r1c0", want.r1c0, inv_r1c0);
                    compare_field("inv_r1c1", want.r1c1, inv_r1c1);
                end
            end

            // track threshold writes
            if (psel && penable && pwrite && pready
                && paddr[PADDR_W-1:ADDR_LSB] == REG_THRESHOLD)
                threshold = pwdata[THR_W-1:0];

            waiting <= inverse_q.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
// ============================================================================
// tb_top - testbench for matrix2x2_inverse
// Drives directed and random matrices through the block under several
// singular thresholds, with random gaps and result stalls, and reports the
// verdict from the checker's failure count.
// ============================================================================
module tb_top
    import mi2_pkg::*;
();

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASES        = 6;
    localparam int RANDOM_ITEMS  = 200;
    localparam int DRAIN_CYCLES  = 60;
    localparam int CALM_PHASE    = 2;

    localparam logic [PADDR_W-1:0] THRESHOLD_ADDR = {REG_THRESHOLD, {ADDR_LSB{1'b0}}};

    typedef logic signed [15:0] elem_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [PADDR_W-1:0]      paddr;
    logic [PDATA_W-1:0]      pwdata;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;
    logic                    item_valid;
    logic                    item_stall;
    elem_t                   elem_r0c0;
    elem_t                   elem_r0c1;
    elem_t                   elem_r1c0;
    elem_t                   elem_r1c1;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    logic                    invertible;
    logic                    saturated;
    logic signed [OUT_W-1:0] inv_r0c0;
    logic signed [OUT_W-1:0] inv_r0c1;
    logic signed [OUT_W-1:0] inv_r1c0;
    logic signed [OUT_W-1:0] inv_r1c1;
    logic                    idle_en;
    int                      failures;
    int                      outstanding;
    int                      cycle_count = 0;

    matrix2x2_inverse dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .elem_r0c0    (elem_r0c0),
        .elem_r0c1    (elem_r0c1),
        .elem_r1c0    (elem_r1c0),
        .elem_r1c1    (elem_r1c1),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .invertible   (invertible),
        .saturated    (saturated),
        .inv_r0c0     (inv_r0c0),
        .inv_r0c1     (inv_r0c1),
        .inv_r1c0     (inv_r1c0),
        .inv_r1c1     (inv_r1c1)
    );

    mi2_inverse_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .elem_r0c0    (elem_r0c0),
        .elem_r0c1    (elem_r0c1),
        .elem_r1c0    (elem_r1c0),
        .elem_r1c1    (elem_r1c1),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .invertible   (invertible),
        .saturated    (saturated),
        .inv_r0c0     (inv_r0c0),
        .inv_r0c1     (inv_r0c1),
        .inv_r1c0     (inv_r1c0),
        .inv_r1c1     (inv_r1c1),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    // Free-running clock
    always #5 clk = ~clk;

    // Stall the result side at random
    always @(negedge clk)
        result_stall <= idle_en && ($urandom_range(0, 99) < 24);

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("matrix2x2_inverse test failed");
            $finish;
        end
    end

    // Present one matrix, with random gaps ahead, and hold it until the transfer
    task automatic send_matrix(input elem_t a, input elem_t b, input elem_t c, input elem_t d);
        @(negedge clk);
        while (idle_en && $urandom_range(0, 99) < 24)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        elem_r0c0  <= a;
        elem_r0c1  <= b;
        elem_r1c0  <= c;
        elem_r1c1  <= d;
        do @(posedge clk); while (item_stall);
    endtask

    // Drop valid and hold off until every result has come back
    task automatic drain_results();
        @(negedge clk);
        item_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
    endtask

    // Register write of the singular threshold: a setup phase, then an access phase
    task automatic write_threshold(input logic [THR_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THRESHOLD_ADDR;
        pwdata  <= {1'b0, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic elem_t corner_value(input int k);
        case (k)
            0:       return -16'sd32768;
            1:       return -16'sd32767;
            2:       return -16'sd1;
            3:       return 16'sd0;
            4:       return 16'sd1;
            5:       return 16'sd256;
            default: return 16'sd32767;
        endcase
    endfunction

    // Random matrix: full range, small values, near singular, or corners
    task automatic send_random_matrix();
        elem_t a;
        elem_t b;
        elem_t c;
        elem_t d;
        int    pick;
        int    near;
        pick = $urandom_range(0, 99);
        a = elem_t'($urandom);
        b = elem_t'($urandom);
        c = elem_t'($urandom);
        d = elem_t'($urandom);
        if (pick < 25)
        begin
            a = elem_t'($urandom_range(0, 1023)) - 16'sd512;
            b = elem_t'($urandom_range(0, 1023)) - 16'sd512;
            c = elem_t'($urandom_range(0, 1023)) - 16'sd512;
            d = elem_t'($urandom_range(0, 1023)) - 16'sd512;
        end
        else if (pick < 50)
        begin
            // choose the last element so the determinant nearly vanishes
            a = elem_t'($urandom_range(0, 4095)) - 16'sd2048;
            b = elem_t'($urandom_range(0, 4095)) - 16'sd2048;
            c = elem_t'($urandom_range(0, 4095)) - 16'sd2048;
            if (a == 0)
                a = 16'sd1;
            near = (int'(b) * int'(c)) / int'(a) + int'($urandom_range(0, 6)) - 3;
            if (near > 32767)
                near = 32767;
            if (near < -32768)
                near = -32768;
            d = elem_t'(near);
        end
        else if (pick < 65)
        begin
            a = corner_value($urandom_range(0, 6));
            b = corner_value($urandom_range(0, 6));
            c = corner_value($urandom_range(0, 6));
            d = corner_value($urandom_range(0, 6));
        end
        send_matrix(a, b, c, d);
    endtask

    initial
    begin
        logic [THR_W-1:0] thr;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        item_valid   = 1'b0;
        idle_en      = 1'b1;
        elem_r0c0    = '0;
        elem_r0c1    = '0;
        elem_r1c0    = '0;
        elem_r1c1    = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed matrices under the reset threshold
        send_matrix(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_matrix(16'sd256, 16'sd0, 16'sd0, 16'sd256);
        send_matrix(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_matrix(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_matrix(-16'sd32768, 16'sd0, 16'sd0, -16'sd32768);
        send_matrix(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767);
        send_matrix(-16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768);
        send_matrix(16'sd1, 16'sd0, 16'sd0, 16'sd1);
        send_matrix(16'sd1, 16'sd32767, 16'sd0, 16'sd1);
        send_matrix(16'sd1, -16'sd32768, 16'sd0, 16'sd1);
        send_matrix(16'sd1, 16'sd0, -16'sd32768, 16'sd1);
        send_matrix(16'sd3, 16'sd1, 16'sd1, 16'sd2);
        send_matrix(-16'sd3, 16'sd1, 16'sd1, 16'sd2);
        send_matrix(16'sd2, 16'sd4, 16'sd1, 16'sd2);
        send_matrix(16'sd32767, -16'sd1, 16'sd1, -16'sd32768);

        // Sweep thresholds; the first phase keeps the reset value
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain_results();
                case (phase)
                    1:       thr = '0;
                    2:       thr = 31'h7FFF_FFFF;
                    3:       thr = 31'd256;
                    4:       thr = 31'd65536;
                    default: thr = THR_W'($urandom_range(0, 1 << 22));
                endcase
                write_threshold(thr);
            end
            idle_en = (phase != CALM_PHASE);

            // boundary determinants around the threshold
            send_matrix(16'sd0, 16'sd0, 16'sd0, 16'sd0);
            send_matrix(16'sd255, 16'sd0, 16'sd0, 16'sd1);
            send_matrix(16'sd16, 16'sd0, 16'sd0, 16'sd16);
            send_matrix(16'sd0, 16'sd1, -16'sd1, 16'sd0);

            for (int n = 0; n < RANDOM_ITEMS; n++)
                send_random_matrix();
        end

        // Wait out the pipeline, then give the verdict
        idle_en = 1'b1;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("matrix2x2_inverse test passed");
        else
            $display("matrix2x2_inverse test failed");
        $finish;
    end

endmodule
